// ===== rtl/jps_pkg.sv =====
// Shared types, constants and codes of the 1D Jacobi Poisson solver.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package jps_pkg;

  // Fixed field widths of the payload and configuration registers.
  localparam int unsigned VALUE_W    = 48;  // signed Q7.40 sample and solution
  localparam int unsigned ERR_W      = 47;  // unsigned change and tolerance
  localparam int unsigned ITER_W     = 20;  // sweep counts
  localparam int unsigned IDX_W      = 9;   // point index field
  localparam int unsigned NPTS_W     = 10;  // n_points register
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 47;

  // Default depth of the point row.
  localparam int unsigned MAX_POINTS_DEF = 512;

  // Register values after reset.
  localparam logic [NPTS_W-1:0] N_POINTS_RST       = 10'd500;
  localparam logic [ERR_W-1:0]  TOLERANCE_RST      = 47'd1099512;
  localparam logic [ITER_W-1:0] MAX_ITERATIONS_RST = 20'd100000;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SOLVE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_N_POINTS       = 2'd0,
    CFG_TOLERANCE      = 2'd1,
    CFG_MAX_ITERATIONS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]                operation;
    logic [IDX_W-1:0]          point_index;
    logic signed [VALUE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] solution_value;
    logic [ITER_W-1:0]         iterations_done;
    logic [ERR_W-1:0]          final_error;
  } out_item_t;

  typedef struct packed {
    logic [NPTS_W-1:0] n_points;
    logic [ERR_W-1:0]  tolerance;
    logic [ITER_W-1:0] max_iterations;
  } cfg_t;

  // Broadcast commands from the controller to every cell of the row.
  typedef struct packed {
    logic                      clear;
    logic                      sweep;
    logic                      shift;
    logic                      load;
    logic [IDX_W-1:0]          idx;
    logic signed [VALUE_W-1:0] data;
  } cell_ctrl_t;

  typedef struct packed {
    logic      load;
    out_item_t item;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/jps_cell.sv =====
// One grid point of the solver row: holds its rhs sample and solution value.
// Depends on jps_pkg for widths and the broadcast command struct.
`default_nettype none

module jps_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire jps_pkg::cell_ctrl_t                ctrl_i,
  input  wire logic [jps_pkg::NPTS_W-1:0]         n_points_i,
  input  wire logic signed [jps_pkg::VALUE_W-1:0] left_i,
  input  wire logic signed [jps_pkg::VALUE_W-1:0] right_i,
  input  wire logic [jps_pkg::ERR_W-1:0]          mx_right_i,
  output logic signed [jps_pkg::VALUE_W-1:0]      value_o,
  output logic [jps_pkg::ERR_W-1:0]               mx_o
);

  localparam int unsigned W     = jps_pkg::VALUE_W;
  localparam int unsigned EW    = jps_pkg::ERR_W;
  localparam int unsigned SUM_W = W + 2;

  localparam logic signed [SUM_W-1:0] VMAX_X = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] VMIN_X = {3'b111, {(W-1){1'b0}}};

  logic signed [W-1:0]     u_q, u_d;
  logic signed [W-1:0]     rhs_q, rhs_d;
  logic [EW-1:0]           d_q, d_d;
  logic [EW-1:0]           mx_q, mx_d;

  logic                    active;
  logic signed [W-1:0]     hl, hr, hs;
  logic signed [SUM_W-1:0] sum3;
  logic                    carry;
  logic                    low;
  logic signed [W-1:0]     new_val;
  logic signed [W:0]       diff;
  logic signed [W:0]       diff_n;
  logic [W:0]              absd;
  logic [EW-1:0]           change;

  always_comb begin
    active = IDX < 32'(n_points_i);

    // floor((l + r + s) / 2) built from the halves plus the carry of the low
    // bits; the halves' sum saturates, then the carry is added within range.
    hl    = left_i >>> 1;
    hr    = right_i >>> 1;
    hs    = rhs_q >>> 1;
    carry = (left_i[0] & right_i[0]) | (left_i[0] & rhs_q[0]) | (right_i[0] & rhs_q[0]);
    sum3  = {{2{hl[W-1]}}, hl} + {{2{hr[W-1]}}, hr} + {{2{hs[W-1]}}, hs}
          + {{(SUM_W-1){1'b0}}, carry};
    low   = carry ? (sum3 <= VMIN_X) : (sum3 < VMIN_X);
    if (low) begin
      new_val = {1'b1, {(W-2){1'b0}}, carry};
    end else if (sum3 > VMAX_X) begin
      new_val = VMAX_X[W-1:0];
    end else begin
      new_val = sum3[W-1:0];
    end

    // Absolute change against the old value, saturated to the error range.
    // Both differences are formed side by side so no negation follows them.
    diff   = {new_val[W-1], new_val} - {u_q[W-1], u_q};
    diff_n = {u_q[W-1], u_q} - {new_val[W-1], new_val};
    absd   = diff[W] ? diff_n : diff;
    change = (absd[W:EW] != '0) ? {EW{1'b1}} : absd[EW-1:0];

    rhs_d = rhs_q;
    if (ctrl_i.load && (32'(ctrl_i.idx) == IDX)) begin
      rhs_d = ctrl_i.data;
    end

    u_d = u_q;
    d_d = d_q;
    if (ctrl_i.clear) begin
      u_d = '0;
    end else if (ctrl_i.sweep) begin
      if (active) begin
        u_d = new_val;
        d_d = change;
      end else begin
        d_d = '0;
      end
    end else if (ctrl_i.shift) begin
      u_d = right_i;
    end

    mx_d = (d_q > mx_right_i) ? d_q : mx_right_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q   <= '0;
      rhs_q <= '0;
    end else begin
      u_q   <= u_d;
      rhs_q <= rhs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q  <= d_d;
    mx_q <= mx_d;
  end

  assign value_o = u_q;
  assign mx_o    = mx_q;

endmodule

`default_nettype wire

// ===== rtl/jps_ctrl.sv =====
// Sequencer of the solver: item decode, sweep loop, copy-out and read memory.
// Depends on jps_pkg for payload, configuration and cell command types.
`default_nettype none

module jps_ctrl #(
  parameter int unsigned MAX_POINTS = jps_pkg::MAX_POINTS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  input  wire jps_pkg::in_item_t                  in_data_i,
  input  wire logic                               out_free_i,
  input  wire jps_pkg::cfg_t                      cfg_i,
  input  wire logic signed [jps_pkg::VALUE_W-1:0] cell_value_i,
  input  wire logic [jps_pkg::ERR_W-1:0]          mx_i,
  output logic                                    in_ready_o,
  output jps_pkg::cell_ctrl_t                     cell_ctrl_o,
  output jps_pkg::res_t                           res_o
);

  localparam int unsigned W  = jps_pkg::VALUE_W;
  localparam int unsigned EW = jps_pkg::ERR_W;
  localparam int unsigned IW = jps_pkg::ITER_W;
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_SWEEP = 6'b000100,
    S_WAIT  = 6'b001000,
    S_COPY  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] iter_q, iter_d;
  logic [EW-1:0] err_q, err_d;
  logic [IW-1:0] sweep_count_q, sweep_count_d;
  logic [EW-1:0] last_err_q, last_err_d;
  logic          sol_valid_q, sol_valid_d;
  logic          rd_ok_q, rd_ok_d;
  logic [W-1:0]  rd_q;
  logic [W-1:0]  mem [MAX_POINTS];

  logic          accept;
  logic [EW-1:0] tol_plus;
  logic [AW-1:0] rd_addr;
  logic          in_range;

  assign in_ready_o = (state_q == S_IDLE) && out_free_i;
  assign accept     = in_valid_i && in_ready_o;
  assign tol_plus   = (&cfg_i.tolerance) ? cfg_i.tolerance : cfg_i.tolerance + EW'(1);
  assign rd_addr    = AW'(in_data_i.point_index);
  assign in_range   = 32'(in_data_i.point_index) < MAX_POINTS;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    iter_d        = iter_q;
    err_d         = err_q;
    sweep_count_d = sweep_count_q;
    last_err_d    = last_err_q;
    sol_valid_d   = sol_valid_q;
    rd_ok_d       = rd_ok_q;

    cell_ctrl_o       = '0;
    cell_ctrl_o.idx   = in_data_i.point_index;
    cell_ctrl_o.data  = in_data_i.sample_value;

    res_o                      = '0;
    res_o.item.iterations_done = sweep_count_q;
    res_o.item.final_error     = last_err_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_data_i.operation)
            jps_pkg::OP_LOAD: begin
              cell_ctrl_o.load = 1'b1;
              res_o.load       = 1'b1;
            end
            jps_pkg::OP_SOLVE: begin
              cell_ctrl_o.clear = 1'b1;
              iter_d            = '0;
              err_d             = tol_plus;
              cnt_d             = '0;
              state_d = (cfg_i.max_iterations == '0) ? S_COPY : S_SWEEP;
            end
            jps_pkg::OP_READ: begin
              rd_ok_d = in_range;
              state_d = S_READ;
            end
            default: begin
              res_o.load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        res_o.load = 1'b1;
        res_o.item.solution_value = (sol_valid_q && rd_ok_q) ? rd_q : '0;
        state_d = S_IDLE;
      end
      S_SWEEP: begin
        cell_ctrl_o.sweep = 1'b1;
        iter_d            = iter_q + IW'(1);
        cnt_d             = '0;
        state_d           = S_WAIT;
      end
      S_WAIT: begin
        // The running maximum passes through the register of each cell on its way to cell zero.
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(MAX_POINTS)) begin
          err_d = mx_i;
          cnt_d = '0;
          if ((mx_i > cfg_i.tolerance) && (iter_q < cfg_i.max_iterations)) begin
            state_d = S_SWEEP;
          end else begin
            state_d = S_COPY;
          end
        end
      end
      S_COPY: begin
        cell_ctrl_o.shift = 1'b1;
        cnt_d             = cnt_q + CW'(1);
        if (cnt_q == CW'(MAX_POINTS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        sweep_count_d              = iter_q;
        last_err_d                 = err_q;
        sol_valid_d                = 1'b1;
        res_o.load                 = 1'b1;
        res_o.item.iterations_done = iter_q;
        res_o.item.final_error     = err_q;
        state_d                    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      iter_q        <= '0;
      err_q         <= '0;
      sweep_count_q <= '0;
      last_err_q    <= '0;
      sol_valid_q   <= 1'b0;
      rd_ok_q       <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      iter_q        <= iter_d;
      err_q         <= err_d;
      sweep_count_q <= sweep_count_d;
      last_err_q    <= last_err_d;
      sol_valid_q   <= sol_valid_d;
      rd_ok_q       <= rd_ok_d;
    end
  end

  // Solution memory: filled in index order by the copy-out shift of the row.
  always_ff @(posedge clk_i) begin
    if (state_q == S_COPY) begin
      mem[cnt_q[AW-1:0]] <= cell_value_i;
    end
    if (accept) begin
      rd_q <= mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.load |-> out_free_i)
    else $error("result produced while the output register is occupied");

  a_cell_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cell_ctrl_o.clear, cell_ctrl_o.sweep, cell_ctrl_o.shift, cell_ctrl_o.load}))
    else $error("more than one cell command at once");

  a_sweep_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> (iter_q < cfg_i.max_iterations))
    else $error("sweep started beyond the iteration limit");

  a_sweep_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |=> (state_q == S_WAIT))
    else $error("sweep not followed by the change reduction");
`endif

endmodule

`default_nettype wire

// ===== rtl/jacobi_poisson_1d_solver.sv =====
// Top level of the 1D Jacobi Poisson solver: config registers, cell row, output register.
// Depends on jps_pkg, jps_cell and jps_ctrl.
//
// Usage: items arrive on in_valid_i/in_ready_o with an in_item_t payload; one
// result beat leaves on out_valid_o/out_ready_i for every accepted item.
// A load beat writes one rhs sample into its cell; its result is in the output
// register in the cycle after acceptance, and loads can be taken every cycle
// while the receiver takes each result. A read beat looks up the solution
// memory into a read register, which then feeds the output register.
// A solve beat zeroes the solution values, then sweeps unless max_iterations is zero.
// Each sweep updates every point below n_points at once, and the maximum
// change then ripples through the row toward cell 0. After the last sweep the
// row shifts its values into the solution memory.
// One item is worked on at a time. The output register holds a finished result
// while the receiver stalls; a new beat is taken once that register is free or
// is being emptied in the same cycle.
// Reset brings the registers to their defaults and clears all rhs samples;
// reads return zero until the first solve has completed.
// Configuration writes are taken at any cycle but are meant for idle times.
`default_nettype none

module jacobi_poisson_1d_solver #(
  parameter int unsigned MAX_POINTS = jps_pkg::MAX_POINTS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire jps_pkg::in_item_t                   in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output jps_pkg::out_item_t                       out_data_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [jps_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [jps_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned W  = jps_pkg::VALUE_W;
  localparam int unsigned EW = jps_pkg::ERR_W;

  jps_pkg::cfg_t       cfg_q, cfg_d;
  logic                out_valid_q, out_valid_d;
  jps_pkg::out_item_t  out_q, out_d;
  logic                out_free;
  jps_pkg::cell_ctrl_t cell_ctrl;
  jps_pkg::res_t       res;

  logic signed [W-1:0] cell_val [MAX_POINTS];
  logic [EW-1:0]       cell_mx  [MAX_POINTS];

  // Configuration registers; writes to an index beyond the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        jps_pkg::CFG_N_POINTS:       cfg_d.n_points       = cfg_data_i[jps_pkg::NPTS_W-1:0];
        jps_pkg::CFG_TOLERANCE:      cfg_d.tolerance      = cfg_data_i[EW-1:0];
        jps_pkg::CFG_MAX_ITERATIONS: cfg_d.max_iterations = cfg_data_i[jps_pkg::ITER_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  // Output register: loaded by the controller only when it is free.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res.load) begin
      out_valid_d = 1'b1;
      out_d       = res.item;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.n_points       <= jps_pkg::N_POINTS_RST;
      cfg_q.tolerance      <= jps_pkg::TOLERANCE_RST;
      cfg_q.max_iterations <= jps_pkg::MAX_ITERATIONS_RST;
      out_valid_q          <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  jps_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .out_free_i   (out_free),
    .cfg_i        (cfg_q),
    .cell_value_i (cell_val[0]),
    .mx_i         (cell_mx[0]),
    .in_ready_o   (in_ready_o),
    .cell_ctrl_o  (cell_ctrl),
    .res_o        (res)
  );

  // The row of cells. Values pass to both neighbors for the stencil; the
  // running maximum of the change and the copy-out shift move toward cell 0.
  // Both ends see zero, which is the fixed boundary value.
  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    logic signed [W-1:0] nb_left;
    logic signed [W-1:0] nb_right;
    logic [EW-1:0]       nb_mx;

    if (g == 0) begin : g_first
      assign nb_left = '0;
    end else begin : g_inner_l
      assign nb_left = cell_val[g-1];
    end

    if (g == MAX_POINTS - 1) begin : g_last
      assign nb_right = '0;
      assign nb_mx    = '0;
    end else begin : g_inner_r
      assign nb_right = cell_val[g+1];
      assign nb_mx    = cell_mx[g+1];
    end

    jps_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .n_points_i (cfg_q.n_points),
      .left_i     (nb_left),
      .right_i    (nb_right),
      .mx_right_i (nb_mx),
      .value_o    (cell_val[g]),
      .mx_o       (cell_mx[g])
    );
  end

endmodule

`default_nettype wire
